// ===== src/rpbt_pkg.sv =====
// Shared types and constants for the retry policy backoff table.
// Used by rpbt_ctrl, rpbt_datapath and retry_policy_backoff_table.
package rpbt_pkg;

  // table geometry
  localparam int POLICY_SLOTS = 8;
  localparam int SLOT_IDX_W   = (POLICY_SLOTS > 1) ? $clog2(POLICY_SLOTS) : 1;
  localparam int COUNT_W      = $clog2(POLICY_SLOTS + 1);

  // field widths
  localparam int ACTION_W = 3;
  localparam int CLASS_W  = 8;
  localparam int LIMIT_W  = 8;
  localparam int BASE_W   = 16;
  localparam int STATUS_W = 2;
  localparam int DELAY_W  = 32;
  localparam int ATTEMPT_W = 8;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_ADD   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ASK   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_NEXT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_RESET = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic load;      // latch the accepted transaction
    logic do_match;  // search the table and register the selected policy
    logic finish;    // update state and load the output register
  } rpbt_cmd_t;

endpackage

// ===== src/rpbt_ctrl.sv =====
// Controller state machine for the retry policy backoff table.
// Depends on rpbt_pkg; drives rpbt_cmd_t to rpbt_datapath.
module rpbt_ctrl import rpbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output rpbt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   in_fire;

  // output register can take a new result
  assign out_free = !out_valid_r || !out_stall;

  // a new transaction enters when idle or as the current one completes
  assign in_stall = !((state_r == S_IDLE) || ((state_r == S_FINISH) && out_free));
  assign in_fire  = in_valid && !in_stall;

  assign cmd.load     = in_fire;
  assign cmd.do_match = (state_r == S_MATCH);
  assign cmd.finish   = (state_r == S_FINISH) && out_free;

  assign out_valid = out_valid_r;

  // next state and output valid
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MATCH;
        end
      end
      S_MATCH: begin
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = in_fire ? S_MATCH : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // a result is only loaded when the output register is free
  a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || !out_stall))
    else $error("result loaded over an unread result");

  // an accepted transaction always goes to the match step
  a_fire_match: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_MATCH))
    else $error("accepted transaction did not reach match");

endmodule

// ===== src/rpbt_datapath.sv =====
// Datapath of the retry policy backoff table: policy registers, class match,
// backoff shift with saturation and the output register. Depends on rpbt_pkg.
module rpbt_datapath import rpbt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  rpbt_cmd_t           cmd,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CLASS_W-1:0]  in_class_id,
  input  logic [LIMIT_W-1:0]  in_retry_limit,
  input  logic [BASE_W-1:0]   in_base_delay_ms,
  input  logic                in_may_retry,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_retry_ok,
  output logic [DELAY_W-1:0]  out_delay_ms
);

  // policy storage, no reset: only entries below the count are read
  logic [CLASS_W-1:0] entry_class_r     [POLICY_SLOTS];
  logic [LIMIT_W-1:0] entry_limit_r     [POLICY_SLOTS];
  logic [BASE_W-1:0]  entry_base_r      [POLICY_SLOTS];
  logic               entry_retryable_r [POLICY_SLOTS];

  logic [COUNT_W-1:0]   entry_count_r, entry_count_nxt;
  logic [ATTEMPT_W-1:0] attempt_r, attempt_nxt;
  logic [CLASS_W-1:0]   current_class_r, current_class_nxt;

  // latched transaction
  logic [ACTION_W-1:0] action_r;
  logic [CLASS_W-1:0]  class_r;
  logic [LIMIT_W-1:0]  limit_r;
  logic [BASE_W-1:0]   base_r;
  logic                may_retry_r;

  // registered match result
  logic               hit_r;
  logic [LIMIT_W-1:0] sel_limit_r;
  logic [BASE_W-1:0]  sel_base_r;
  logic               sel_retry_r;

  logic [CLASS_W-1:0]    key;
  logic                  hit;
  logic [SLOT_IDX_W-1:0] sel;
  logic                  add_ok;

  logic [STATUS_W-1:0] status_nxt;
  logic                ok_nxt;
  logic [DELAY_W-1:0]  delay_nxt;
  logic [DELAY_W+BASE_W-1:0] shifted;
  logic [DELAY_W-1:0]  scaled;

  // capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_r    <= in_action;
      class_r     <= in_class_id;
      limit_r     <= in_retry_limit;
      base_r      <= in_base_delay_ms;
      may_retry_r <= in_may_retry;
    end
  end

  // first matching policy: ask uses the given class, backoff the current one
  assign key = (action_r == ACT_ASK) ? class_r : current_class_r;

  always_comb begin
    hit = 1'b0;
    sel = '0;
    for (int i = POLICY_SLOTS - 1; i >= 0; i--) begin
      if ((COUNT_W'(i) < entry_count_r) && (entry_class_r[i] == key)) begin
        hit = 1'b1;
        sel = SLOT_IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_match) begin
      hit_r       <= hit;
      sel_limit_r <= entry_limit_r[sel];
      sel_base_r  <= entry_base_r[sel];
      sel_retry_r <= entry_retryable_r[sel];
    end
  end

  // base doubled per prior attempt, saturated to 32 bits
  assign shifted = (DELAY_W + BASE_W)'(sel_base_r) << attempt_r[4:0];

  always_comb begin
    if (sel_base_r == '0) begin
      scaled = '0;
    end else if ((attempt_r[ATTEMPT_W-1:5] != '0) ||
                 (shifted[DELAY_W+BASE_W-1:DELAY_W] != '0)) begin
      scaled = '1;
    end else begin
      scaled = shifted[DELAY_W-1:0];
    end
  end

  assign add_ok = (entry_count_r < COUNT_W'(POLICY_SLOTS));

  // result and state update for the finishing transaction
  always_comb begin
    status_nxt        = ST_OK;
    ok_nxt            = 1'b0;
    delay_nxt         = '0;
    entry_count_nxt   = entry_count_r;
    attempt_nxt       = attempt_r;
    current_class_nxt = current_class_r;
    case (action_r)
      ACT_ADD: begin
        if (add_ok) begin
          entry_count_nxt = entry_count_r + COUNT_W'(1);
        end else begin
          status_nxt = ST_FULL;
        end
      end
      ACT_ASK: begin
        current_class_nxt = class_r;
        if (!hit_r) begin
          status_nxt = ST_NOMATCH;
        end else begin
          ok_nxt = sel_retry_r && (attempt_r < sel_limit_r);
        end
      end
      ACT_NEXT: begin
        if (!hit_r) begin
          status_nxt = ST_NOMATCH;
        end else begin
          delay_nxt = scaled;
          if (attempt_r != '1) begin
            attempt_nxt = attempt_r + ATTEMPT_W'(1);
          end
        end
      end
      ACT_RESET: begin
        attempt_nxt = '0;
      end
      ACT_CLEAR: begin
        entry_count_nxt   = '0;
        attempt_nxt       = '0;
        current_class_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  // policy write on add
  always_ff @(posedge clk) begin
    if (cmd.finish && (action_r == ACT_ADD) && add_ok) begin
      entry_class_r[entry_count_r[SLOT_IDX_W-1:0]]     <= class_r;
      entry_limit_r[entry_count_r[SLOT_IDX_W-1:0]]     <= limit_r;
      entry_base_r[entry_count_r[SLOT_IDX_W-1:0]]      <= base_r;
      entry_retryable_r[entry_count_r[SLOT_IDX_W-1:0]] <= may_retry_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      attempt_r       <= '0;
      current_class_r <= '0;
    end else if (cmd.finish) begin
      entry_count_r   <= entry_count_nxt;
      attempt_r       <= attempt_nxt;
      current_class_r <= current_class_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_status   <= status_nxt;
      out_retry_ok <= ok_nxt;
      out_delay_ms <= delay_nxt;
    end
  end

  // the table never holds more policies than it has slots
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= COUNT_W'(POLICY_SLOTS))
    else $error("policy count beyond table size");

  // state only moves when a transaction finishes
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.finish |=> ($stable(entry_count_r) && $stable(attempt_r)))
    else $error("table state changed outside a finish");

  // a nonzero delay only comes from a matched backoff
  a_delay_src: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && ((action_r != ACT_NEXT) || !hit_r)) |=> (out_delay_ms == '0))
    else $error("delay reported without a matched backoff");

endmodule

// ===== src/retry_policy_backoff_table.sv =====
// Retry policy table with exponential backoff. Each transaction passes
// through a match step, which searches the eight policy registers for the
// first matching class and registers the selected policy, and a finish step,
// which forms the answer (retry decision or saturating shifted backoff) and
// updates the table state. The result is loaded into the output register in
// the finish step once that register is free. A new transaction is taken
// when idle or in the same cycle that the previous one completes. A held
// result does not block the next transaction from being accepted and searched.
// Top level: joins rpbt_ctrl and rpbt_datapath; depends on rpbt_pkg.
module retry_policy_backoff_table import rpbt_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [ACTION_W-1:0] in_action,
  input  logic [CLASS_W-1:0]  in_class_id,
  input  logic [LIMIT_W-1:0]  in_retry_limit,
  input  logic [BASE_W-1:0]   in_base_delay_ms,
  input  logic                in_may_retry,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic                out_retry_ok,
  output logic [DELAY_W-1:0]  out_delay_ms
);

  rpbt_cmd_t cmd;

  // sequencing and handshakes
  rpbt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // policy table and arithmetic
  rpbt_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_action        (in_action),
    .in_class_id      (in_class_id),
    .in_retry_limit   (in_retry_limit),
    .in_base_delay_ms (in_base_delay_ms),
    .in_may_retry     (in_may_retry),
    .out_status       (out_status),
    .out_retry_ok     (out_retry_ok),
    .out_delay_ms     (out_delay_ms)
  );

endmodule
